// ----- rtl/aps_pkg.sv -----
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants for the ATA PIO sector sequencer.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int CfgWidth = 24;
    localparam int LbaWidth = 28;
    localparam int DefaultSectorWords = 256;

    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_IDENT  = 3'd2;
    localparam logic [2:0] CMD_STATUS = 3'd3;
    localparam logic [2:0] CMD_DATA   = 3'd4;
    localparam logic [2:0] CMD_RESET  = 3'd5;

    localparam logic [1:0] CFG_BUSY_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_DRQ_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_IDENT_LIMIT = 2'd2;

    localparam logic [3:0] REG_DATA    = 4'd0;
    localparam logic [3:0] REG_COUNT   = 4'd2;
    localparam logic [3:0] REG_LBA0    = 4'd3;
    localparam logic [3:0] REG_LBA1    = 4'd4;
    localparam logic [3:0] REG_LBA2    = 4'd5;
    localparam logic [3:0] REG_SELECT  = 4'd6;
    localparam logic [3:0] REG_CMD     = 4'd7;
    localparam logic [3:0] REG_CONTROL = 4'd8;

    localparam logic [7:0] ST_BSY = 8'h80;
    localparam logic [7:0] ST_DRQ = 8'h08;
    localparam logic [7:0] ST_ERR = 8'h01;

    localparam logic [7:0] ATA_READ_SECTORS  = 8'h20;
    localparam logic [7:0] ATA_WRITE_SECTORS = 8'h30;
    localparam logic [7:0] ATA_IDENTIFY      = 8'hEC;
    localparam logic [7:0] SEL_LBA_MASTER    = 8'hE0;
    localparam logic [7:0] SEL_MASTER        = 8'hA0;
    localparam logic [7:0] SEL_SLAVE         = 8'hB0;
    localparam logic [7:0] CTRL_SRST         = 8'h04;

    localparam logic [1:0] OC_OK       = 2'd0;
    localparam logic [1:0] OC_ERROR    = 2'd1;
    localparam logic [1:0] OC_NO_DRIVE = 2'd2;

    localparam logic [23:0] RST_BUSY_LIMIT  = 24'd1000000;
    localparam logic [23:0] RST_DRQ_LIMIT   = 24'd10000000;
    localparam logic [23:0] RST_IDENT_LIMIT = 24'd1000000;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_BUSY  = 5'b00010,
        PH_DRQ   = 5'b00100,
        PH_IDENT = 5'b01000,
        PH_XFER  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_IDENT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        K_SINGLE = 2'd0,
        K_SETUP  = 2'd1,
        K_IDENT  = 2'd2,
        K_RESET  = 2'd3
    } kind_t;

    typedef struct packed {
        logic        req;
        logic        wr;
        logic [3:0]  regsel;
        logic [15:0] value;
        logic        wv;
        logic [15:0] word;
        logic        fin;
        logic [1:0]  oc;
    } res_t;

    typedef struct packed {
        kind_t                kind;
        logic [2:0]           last_step;
        logic [LbaWidth-1:0]  addr;
        logic                 slave;
        logic                 wr_op;
        res_t                 tail;
    } desc_t;

    function automatic res_t res_none();
        res_t r;
        r = '0;
        return r;
    endfunction

    function automatic res_t res_rd(input logic [3:0] regsel);
        res_t r;
        r = '0;
        r.req = 1'b1;
        r.regsel = regsel;
        return r;
    endfunction

    function automatic res_t res_wr(input logic [3:0] regsel, input logic [15:0] value);
        res_t r;
        r = '0;
        r.req = 1'b1;
        r.wr = 1'b1;
        r.regsel = regsel;
        r.value = value;
        return r;
    endfunction

    function automatic res_t res_fin(input logic [1:0] oc);
        res_t r;
        r = '0;
        r.fin = 1'b1;
        r.oc = oc;
        return r;
    endfunction

endpackage

// ----- rtl/aps_front.sv -----
// ----------------------------------------------------------------------------
// aps_front
// Accepts requests, tracks the sequencer phase and emits burst descriptors.
// ----------------------------------------------------------------------------
module aps_front #(
    parameter int SECTOR_WORDS = aps_pkg::DefaultSectorWords
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [aps_pkg::CfgWidth-1:0] cfg_data,
    input  logic                        accept,
    input  logic [2:0]                  command,
    input  logic [aps_pkg::LbaWidth-1:0] lba,
    input  logic                        drive_slave,
    input  logic [7:0]                  status_byte,
    input  logic [15:0]                 data_word,
    output logic                        push,
    output aps_pkg::desc_t              push_desc
);
    import aps_pkg::*;

    localparam int WcWidth = $clog2(SECTOR_WORDS + 1);

    logic [CfgWidth-1:0] busy_lim_reg, drq_lim_reg, ident_lim_reg;
    phase_t              phase_reg, phase_next;
    op_t                 op_reg, op_next;
    logic [LbaWidth-1:0] addr_reg, addr_next;
    logic [CfgWidth-1:0] pc_reg, pc_next, pc_inc;
    logic [WcWidth-1:0]  wc_reg, wc_next;
    logic                first_reg, first_next;
    logic [WcWidth:0]    wc_inc;
    logic                done;
    logic                emit;
    desc_t               d;

    assign pc_inc = pc_reg + 1'b1;
    assign wc_inc = {1'b0, wc_reg} + 1'b1;
    assign done = wc_inc >= (WcWidth+1)'(SECTOR_WORDS);

    always_comb
    begin
        phase_next = phase_reg;
        op_next = op_reg;
        addr_next = addr_reg;
        pc_next = pc_reg;
        wc_next = wc_reg;
        first_next = first_reg;
        emit = 1'b0;
        d = '0;
        d.kind = K_SINGLE;
        d.addr = addr_reg;
        d.wr_op = (op_reg == OP_WRITE);
        d.slave = drive_slave;
        case (command)
            CMD_READ, CMD_WRITE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    op_next = (command == CMD_READ) ? OP_READ : OP_WRITE;
                    addr_next = lba;
                    pc_next = '0;
                    phase_next = PH_BUSY;
                    emit = 1'b1;
                    d.tail = res_rd(REG_CMD);
                end
            end
            CMD_IDENT:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    op_next = OP_IDENT;
                    first_next = 1'b1;
                    pc_next = '0;
                    phase_next = PH_IDENT;
                    emit = 1'b1;
                    d.kind = K_IDENT;
                    d.last_step = 3'd2;
                end
            end
            CMD_STATUS:
            begin
                case (phase_reg)
                    PH_BUSY:
                    begin
                        emit = 1'b1;
                        if ((status_byte & ST_BSY) != '0 && pc_reg < busy_lim_reg)
                        begin
                            pc_next = pc_inc;
                            d.tail = res_rd(REG_CMD);
                        end
                        else
                        begin
                            d.kind = K_SETUP;
                            d.last_step = 3'd7;
                            pc_next = '0;
                            if (drq_lim_reg != '0)
                            begin
                                phase_next = PH_DRQ;
                                d.tail = res_rd(REG_CMD);
                            end
                            else
                            begin
                                phase_next = PH_XFER;
                                wc_next = '0;
                                if (op_reg == OP_WRITE)
                                begin
                                    d.last_step = 3'd6;
                                end
                                else
                                begin
                                    d.tail = res_rd(REG_DATA);
                                end
                            end
                        end
                    end
                    PH_DRQ:
                    begin
                        pc_next = pc_inc;
                        if ((status_byte & ST_ERR) != '0)
                        begin
                            emit = 1'b1;
                            d.tail = res_fin(OC_ERROR);
                            phase_next = PH_IDLE;
                        end
                        else if ((status_byte & ST_DRQ) == '0 && pc_inc < drq_lim_reg)
                        begin
                            emit = 1'b1;
                            d.tail = res_rd(REG_CMD);
                        end
                        else
                        begin
                            phase_next = PH_XFER;
                            wc_next = '0;
                            emit = (op_reg != OP_WRITE);
                            d.tail = res_rd(REG_DATA);
                        end
                    end
                    PH_IDENT:
                    begin
                        emit = 1'b1;
                        if (first_reg)
                        begin
                            first_next = 1'b0;
                            pc_next = '0;
                            if (status_byte == 8'h00 || status_byte == 8'hFF
                                || ident_lim_reg == '0)
                            begin
                                d.tail = res_fin(OC_NO_DRIVE);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                d.tail = res_rd(REG_CMD);
                            end
                        end
                        else
                        begin
                            pc_next = pc_inc;
                            if ((status_byte & ST_DRQ) != '0)
                            begin
                                phase_next = PH_XFER;
                                wc_next = '0;
                                d.tail = res_rd(REG_DATA);
                            end
                            else if ((status_byte & ST_ERR) != '0)
                            begin
                                d.tail = res_fin(OC_ERROR);
                                phase_next = PH_IDLE;
                            end
                            else if (pc_inc < ident_lim_reg)
                            begin
                                d.tail = res_rd(REG_CMD);
                            end
                            else
                            begin
                                d.tail = res_fin(OC_NO_DRIVE);
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
            CMD_DATA:
            begin
                if (phase_reg == PH_XFER)
                begin
                    emit = 1'b1;
                    wc_next = wc_inc[WcWidth-1:0];
                    if (op_reg == OP_WRITE)
                    begin
                        d.tail = res_wr(REG_DATA, data_word);
                    end
                    else
                    begin
                        d.tail = done ? res_none() : res_rd(REG_DATA);
                        d.tail.wv = (op_reg == OP_READ);
                        d.tail.word = (op_reg == OP_READ) ? data_word : 16'h0000;
                    end
                    d.tail.fin = done;
                    if (done)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            CMD_RESET:
            begin
                emit = 1'b1;
                d.kind = K_RESET;
                d.last_step = 3'd1;
                phase_next = PH_IDLE;
                first_next = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign push = accept && emit;
    assign push_desc = d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_lim_reg <= RST_BUSY_LIMIT;
            drq_lim_reg <= RST_DRQ_LIMIT;
            ident_lim_reg <= RST_IDENT_LIMIT;
            phase_reg <= PH_IDLE;
            op_reg <= OP_READ;
            addr_reg <= '0;
            pc_reg <= '0;
            wc_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_BUSY_LIMIT:  busy_lim_reg <= cfg_data;
                    CFG_DRQ_LIMIT:   drq_lim_reg <= cfg_data;
                    CFG_IDENT_LIMIT: ident_lim_reg <= cfg_data;
                    default:         busy_lim_reg <= busy_lim_reg;
                endcase
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                op_reg <= op_next;
                addr_reg <= addr_next;
                pc_reg <= pc_next;
                wc_reg <= wc_next;
                first_reg <= first_next;
            end
        end
    end

endmodule

// ----- rtl/aps_queue.sv -----
// ----------------------------------------------------------------------------
// aps_queue
// Small descriptor FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module aps_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aps_pkg::desc_t push_desc,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output aps_pkg::desc_t head
);
    import aps_pkg::*;

    localparam int Depth = 4;
    localparam int PtrWidth = $clog2(Depth);

    desc_t               mem [Depth];
    logic [PtrWidth-1:0] wp_reg, rp_reg;
    logic [PtrWidth:0]   cnt_reg;

    assign full = (cnt_reg == (PtrWidth+1)'(Depth));
    assign empty = (cnt_reg == '0);
    assign head = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/aps_back.sv -----
// ----------------------------------------------------------------------------
// aps_back
// Expands descriptors into output-stage results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module aps_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  aps_pkg::desc_t head,
    output logic           pop,
    input  logic           out_stall,
    output logic           out_valid,
    output aps_pkg::res_t  out_res,
    output logic           out_last
);
    import aps_pkg::*;

    logic [2:0] step_reg;
    logic       ov_reg;
    res_t       res_reg;
    logic       last_reg;
    res_t       r;
    logic       adv;
    logic       is_last;

    assign adv = !empty && (!ov_reg || !out_stall);
    assign is_last = (step_reg == head.last_step);
    assign pop = adv && is_last;

    always_comb
    begin
        r = head.tail;
        case (head.kind)
            K_SETUP:
            begin
                case (step_reg)
                    3'd0: r = res_wr(REG_SELECT, {8'h00, SEL_LBA_MASTER});
                    3'd1: r = res_wr(REG_COUNT, 16'h0001);
                    3'd2: r = res_wr(REG_LBA0, {8'h00, head.addr[7:0]});
                    3'd3: r = res_wr(REG_LBA1, {8'h00, head.addr[15:8]});
                    3'd4: r = res_wr(REG_LBA2, {8'h00, head.addr[23:16]});
                    3'd5: r = res_wr(REG_SELECT,
                                     {8'h00, SEL_LBA_MASTER | {4'h0, head.addr[27:24]}});
                    3'd6: r = res_wr(REG_CMD, {8'h00, head.wr_op ? ATA_WRITE_SECTORS
                                                                 : ATA_READ_SECTORS});
                    default: r = head.tail;
                endcase
            end
            K_IDENT:
            begin
                case (step_reg)
                    3'd0: r = res_wr(REG_SELECT, {8'h00, head.slave ? SEL_SLAVE
                                                                    : SEL_MASTER});
                    3'd1: r = res_wr(REG_CMD, {8'h00, ATA_IDENTIFY});
                    default: r = res_rd(REG_CMD);
                endcase
            end
            K_RESET:
            begin
                if (step_reg == 3'd0)
                begin
                    r = res_wr(REG_CONTROL, {8'h00, CTRL_SRST});
                end
                else
                begin
                    r = res_wr(REG_CONTROL, 16'h0000);
                    r.fin = 1'b1;
                    r.oc = OC_OK;
                end
            end
            default:
            begin
                r = head.tail;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= r;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                ov_reg <= 1'b1;
                step_reg <= is_last ? 3'd0 : step_reg + 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_res = res_reg;
    assign out_last = last_reg;

endmodule

// ----- rtl/ata_pio_sector_sequencer.sv -----
// ----------------------------------------------------------------------------
// ata_pio_sector_sequencer
// Host-side ATA PIO sequencer for one sector with 28-bit LBA addressing.
//
// Channel   Handshake             Payload
// input     in_valid / in_stall   command, lba, drive_slave, status_byte, data_word
// output    out_valid / out_stall bus_*, word_valid, sector_word, finished, outcome, last
// config    cfg_write             cfg_index, cfg_data
//
// A request is classified in the cycle it is accepted; one request is taken per cycle
// while the descriptor queue is not full. The back part produces the results of each
// request one at a time; a four-entry descriptor queue separates the two parts.
// in_stall rises only when that queue is full; out_stall holds the output register.
// Reset is asynchronous and clears all control state and loads the poll limits.
// ----------------------------------------------------------------------------
module ata_pio_sector_sequencer #(
    parameter int SECTOR_WORDS = aps_pkg::DefaultSectorWords
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [1:0]                   cfg_index,
    input  logic [aps_pkg::CfgWidth-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   command,
    input  logic [aps_pkg::LbaWidth-1:0] lba,
    input  logic                         drive_slave,
    input  logic [7:0]                   status_byte,
    input  logic [15:0]                  data_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         bus_request,
    output logic                         bus_write,
    output logic [3:0]                   bus_register,
    output logic [15:0]                  bus_value,
    output logic                         word_valid,
    output logic [15:0]                  sector_word,
    output logic                         finished,
    output logic [1:0]                   outcome,
    output logic                         last
);
    import aps_pkg::*;

    logic  accept, push, pop, full, empty;
    desc_t push_desc, head;
    res_t  res;

    assign in_stall = full;
    assign accept = in_valid && !full;

    aps_front #(.SECTOR_WORDS(SECTOR_WORDS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .accept(accept), .command(command), .lba(lba), .drive_slave(drive_slave),
        .status_byte(status_byte), .data_word(data_word),
        .push(push), .push_desc(push_desc)
    );

    aps_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_desc(push_desc),
        .pop(pop), .full(full), .empty(empty), .head(head)
    );

    aps_back u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .head(head), .pop(pop),
        .out_stall(out_stall), .out_valid(out_valid), .out_res(res), .out_last(last)
    );

    assign bus_request = res.req;
    assign bus_write = res.wr;
    assign bus_register = res.regsel;
    assign bus_value = res.value;
    assign word_valid = res.wv;
    assign sector_word = res.word;
    assign finished = res.fin;
    assign outcome = res.oc;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("descriptor queue overflow");

    a_fin_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (!bus_request || bus_write))
        else $error("finishing result carries a read access");

    a_word_not_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && word_valid) |-> !bus_write)
        else $error("sector word on a write access");

endmodule

// ----- bench/tb_ata_pio_sector_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ata_pio_sector_sequencer
// Self-checking bench for the ATA PIO sector sequencer. Requests are driven
// through the valid/stall channel and each accepted request is run through
// an in-bench model of the sequencer. The register accesses, sector words and
// completions it predicts are compared with every result the block returns.
// ----------------------------------------------------------------------------
module tb_ata_pio_sector_sequencer;

    import aps_pkg::*;

    typedef struct {
        res_t r;
        logic last;
    } bus_step_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [27:0] lba;
    logic        drive_slave;
    logic [7:0]  status_byte;
    logic [15:0] data_word;
    logic        out_valid;
    logic        out_stall;
    logic        bus_request;
    logic        bus_write;
    logic [3:0]  bus_register;
    logic [15:0] bus_value;
    logic        word_valid;
    logic [15:0] sector_word;
    logic        finished;
    logic [1:0]  outcome;
    logic        last;

    bus_step_t   expected_steps[$];
    res_t        step_buf[$];
    int          errors;
    int          items_sent;
    bit          hold_request;
    bit          quiet_sender;

    logic [23:0] busy_limit;
    logic [23:0] drq_limit;
    logic [23:0] ident_limit;
    phase_t      seq_phase;
    op_t         seq_op;
    logic [27:0] seq_addr;
    logic [23:0] poll_cnt;
    logic [8:0]  word_cnt;
    logic        first_poll;

    ata_pio_sector_sequencer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .lba          (lba),
        .drive_slave  (drive_slave),
        .status_byte  (status_byte),
        .data_word    (data_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bus_request  (bus_request),
        .bus_write    (bus_write),
        .bus_register (bus_register),
        .bus_value    (bus_value),
        .word_valid   (word_valid),
        .sector_word  (sector_word),
        .finished     (finished),
        .outcome      (outcome),
        .last         (last)
    );

    always #5 clk = ~clk;

    function automatic res_t access_read(input logic [3:0] regsel);
        res_t r;
        r = '0;
        r.req = 1'b1;
        r.regsel = regsel;
        return r;
    endfunction

    function automatic res_t access_write(input logic [3:0] regsel, input logic [15:0] v);
        res_t r;
        r = access_read(regsel);
        r.wr = 1'b1;
        r.value = v;
        return r;
    endfunction

    function automatic res_t completion(input logic [1:0] oc);
        res_t r;
        r = '0;
        r.fin = 1'b1;
        r.oc = oc;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet_sender || p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    task automatic finish_op(input logic [1:0] oc);
        step_buf.push_back(completion(oc));
        seq_phase = PH_IDLE;
    endtask

    task automatic begin_transfer();
        seq_phase = PH_XFER;
        word_cnt = '0;
        if (seq_op != OP_WRITE)
            step_buf.push_back(access_read(REG_DATA));
    endtask

    task automatic issue_command();
        step_buf.push_back(access_write(REG_SELECT, 16'(SEL_LBA_MASTER)));
        step_buf.push_back(access_write(REG_COUNT, 16'd1));
        step_buf.push_back(access_write(REG_LBA0, 16'(seq_addr[7:0])));
        step_buf.push_back(access_write(REG_LBA1, 16'(seq_addr[15:8])));
        step_buf.push_back(access_write(REG_LBA2, 16'(seq_addr[23:16])));
        step_buf.push_back(access_write(REG_SELECT,
            16'(SEL_LBA_MASTER | {4'h0, seq_addr[27:24]})));
        step_buf.push_back(access_write(REG_CMD, 16'(seq_op == OP_WRITE ?
            ATA_WRITE_SECTORS : ATA_READ_SECTORS)));
        seq_phase = PH_DRQ;
        poll_cnt = '0;
        if (drq_limit > 0)
            step_buf.push_back(access_read(REG_CMD));
        else
            begin_transfer();
    endtask

    task automatic handle_status(input logic [7:0] s);
        case (seq_phase)
            PH_BUSY:
            begin
                if ((s & ST_BSY) != 0 && poll_cnt < busy_limit)
                begin
                    poll_cnt++;
                    step_buf.push_back(access_read(REG_CMD));
                end
                else
                    issue_command();
            end
            PH_DRQ:
            begin
                poll_cnt++;
                if ((s & ST_ERR) != 0)
                    finish_op(OC_ERROR);
                else if ((s & ST_DRQ) != 0)
                    begin_transfer();
                else if (poll_cnt < drq_limit)
                    step_buf.push_back(access_read(REG_CMD));
                else
                    begin_transfer();
            end
            PH_IDENT:
            begin
                if (first_poll)
                begin
                    first_poll = 1'b0;
                    poll_cnt = '0;
                    if (s == 8'h00 || s == 8'hFF || ident_limit == 0)
                        finish_op(OC_NO_DRIVE);
                    else
                        step_buf.push_back(access_read(REG_CMD));
                end
                else
                begin
                    poll_cnt++;
                    if ((s & ST_DRQ) != 0)
                        begin_transfer();
                    else if ((s & ST_ERR) != 0)
                        finish_op(OC_ERROR);
                    else if (poll_cnt < ident_limit)
                        step_buf.push_back(access_read(REG_CMD));
                    else
                        finish_op(OC_NO_DRIVE);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic handle_word(input logic [15:0] w);
        res_t r;
        logic done;
        if (seq_phase == PH_XFER)
        begin
            word_cnt++;
            done = word_cnt >= 9'd256;
            r = '0;
            if (seq_op == OP_WRITE)
                r = access_write(REG_DATA, w);
            else
            begin
                r.req = ~done;
                r.wv = seq_op == OP_READ;
                r.word = seq_op == OP_READ ? w : 16'h0;
            end
            r.fin = done;
            step_buf.push_back(r);
            if (done)
                seq_phase = PH_IDLE;
        end
    endtask

    task automatic predict_request(input logic [2:0] cmd, input logic [27:0] a,
                                   input logic sl, input logic [7:0] s,
                                   input logic [15:0] w);
        bus_step_t e;
        step_buf.delete();
        case (cmd)
            CMD_READ, CMD_WRITE:
            begin
                if (seq_phase == PH_IDLE)
                begin
                    seq_op = cmd == CMD_READ ? OP_READ : OP_WRITE;
                    seq_addr = a;
                    poll_cnt = '0;
                    seq_phase = PH_BUSY;
                    step_buf.push_back(access_read(REG_CMD));
                end
            end
            CMD_IDENT:
            begin
                if (seq_phase == PH_IDLE)
                begin
                    seq_op = OP_IDENT;
                    step_buf.push_back(access_write(REG_SELECT,
                        16'(sl ? SEL_SLAVE : SEL_MASTER)));
                    step_buf.push_back(access_write(REG_CMD, 16'(ATA_IDENTIFY)));
                    step_buf.push_back(access_read(REG_CMD));
                    first_poll = 1'b1;
                    poll_cnt = '0;
                    seq_phase = PH_IDENT;
                end
            end
            CMD_STATUS: handle_status(s);
            CMD_DATA: handle_word(w);
            CMD_RESET:
            begin
                step_buf.push_back(access_write(REG_CONTROL, 16'(CTRL_SRST)));
                e.r = access_write(REG_CONTROL, 16'h0);
                e.r.fin = 1'b1;
                step_buf.push_back(e.r);
                seq_phase = PH_IDLE;
                first_poll = 1'b0;
            end
            default:
            begin
            end
        endcase
        foreach (step_buf[i])
        begin
            e.r = step_buf[i];
            e.last = i == step_buf.size() - 1;
            expected_steps.push_back(e);
        end
    endtask

    task automatic send_request(input logic [2:0] cmd, input logic [27:0] a,
                                input logic sl, input logic [7:0] s,
                                input logic [15:0] w);
        int gap;
        in_valid <= 1'b1;
        command <= cmd;
        lba <= a;
        drive_slave <= sl;
        status_byte <= s;
        data_word <= w;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(cmd, a, sl, s, w);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_status(input logic [7:0] s);
        send_request(CMD_STATUS, 28'($urandom), 1'($urandom), s, 16'($urandom));
    endtask

    task automatic send_word(input logic [15:0] w);
        send_request(CMD_DATA, 28'($urandom), 1'($urandom), 8'($urandom), w);
    endtask

    task automatic send_start(input logic [2:0] cmd, input logic [27:0] a);
        send_request(cmd, a, 1'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic send_identify(input logic sl);
        send_request(CMD_IDENT, 28'($urandom), sl, 8'($urandom), 16'($urandom));
    endtask

    task automatic send_soft_reset();
        send_start(CMD_RESET, 28'($urandom));
    endtask

    task automatic drain();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (expected_steps.size() > 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic set_limits(input logic [23:0] b, input logic [23:0] d,
                              input logic [23:0] id);
        logic [23:0] v[3];
        drain();
        v[0] = b;
        v[1] = d;
        v[2] = id;
        for (int i = 0; i < 3; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= v[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        busy_limit = b;
        drq_limit = d;
        ident_limit = id;
    endtask

    function automatic logic [7:0] poll_value(input logic [7:0] must_set,
                                              input logic [7:0] must_clear);
        return (8'($urandom) | must_set) & ~must_clear;
    endfunction

    task automatic transfer_words(input bit full);
        int n;
        n = full ? 256 : $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_status(8'($urandom));
            send_word(16'($urandom));
        end
        if (!full)
            send_soft_reset();
    endtask

    task automatic run_sector_sequence(input bit full);
        logic [2:0] cmd;
        cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        send_start(cmd, 28'($urandom));
        repeat ($urandom_range(0, 3)) send_status(poll_value(ST_BSY, 8'h00));
        send_status(poll_value(8'h00, ST_BSY));
        repeat ($urandom_range(0, 3)) send_status(poll_value(8'h00, ST_DRQ | ST_ERR));
        if ($urandom_range(0, 5) == 0)
            send_status(poll_value(ST_ERR, 8'h00));
        else
        begin
            send_status(poll_value(ST_DRQ, ST_ERR));
            transfer_words(full);
        end
    endtask

    task automatic run_identify_sequence(input bit full);
        int p;
        send_identify(1'($urandom));
        p = $urandom_range(0, 9);
        if (p == 0)
            send_status(8'h00);
        else if (p == 1)
            send_status(8'hFF);
        else
        begin
            send_status(poll_value(8'h01, 8'h00));
            repeat ($urandom_range(0, 3)) send_status(poll_value(8'h00, ST_DRQ | ST_ERR));
            if ($urandom_range(0, 4) == 0)
                send_status(poll_value(ST_ERR, ST_DRQ));
            else
            begin
                send_status(poll_value(ST_DRQ, 8'h00));
                transfer_words(full);
            end
        end
    endtask

    task automatic run_noise();
        send_request(3'($urandom), 28'($urandom), 1'($urandom), 8'($urandom),
                     16'($urandom));
    endtask

    task automatic test_directed();
        send_start(CMD_READ, 28'hFFFFFFF);
        send_start(CMD_WRITE, 28'h0);
        send_status(8'h80);
        send_status(8'h7F);
        send_status(8'h00);
        send_status(8'h01);
        send_start(CMD_WRITE, 28'h5A5A5A5);
        send_word(16'hFFFF);
        send_status(8'h00);
        send_status(8'h08);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_request(3'd6, 28'hFFFFFFF, 1'b1, 8'hFF, 16'hFFFF);
        send_request(3'd7, 28'h0, 1'b0, 8'h00, 16'h0);
        send_soft_reset();
        send_identify(1'b1);
        send_status(8'h00);
        send_identify(1'b0);
        send_status(8'hFF);
        send_identify(1'b0);
        send_status(8'h50);
        send_status(8'h01);
        send_status(8'h40);
        send_soft_reset();
    endtask

    task automatic test_full_sectors();
        set_limits(24'd4, 24'd4, 24'd4);
        quiet_sender = 1'b1;
        send_start(CMD_READ, 28'hABCDEF0);
        send_status(8'h00);
        send_status(8'h08);
        transfer_words(1'b1);
        quiet_sender = 1'b0;
    endtask

    task automatic test_limit_extremes();
        logic [23:0] ext[4] = '{24'd0, 24'd1, 24'd2, 24'hFFFFFF};
        foreach (ext[i])
        begin
            set_limits(ext[i], ext[3 - i], ext[(i + 1) % 4]);
            run_sector_sequence(1'b0);
            run_identify_sequence(1'b0);
        end
    endtask

    task automatic test_backpressure();
        set_limits(24'd3, 24'd3, 24'd3);
        hold_request = 1'b1;
        quiet_sender = 1'b1;
        repeat (3)
        begin
            run_identify_sequence(1'b0);
            send_soft_reset();
        end
        quiet_sender = 1'b0;
    endtask

    task automatic test_random();
        int p;
        set_limits(RST_BUSY_LIMIT, RST_DRQ_LIMIT, RST_IDENT_LIMIT);
        while (items_sent < 400)
        begin
            p = $urandom_range(0, 99);
            if (p < 45)
                run_sector_sequence(1'b0);
            else if (p < 80)
                run_identify_sequence(1'b0);
            else
                run_noise();
            if ($urandom_range(0, 59) == 0)
                set_limits(24'($urandom_range(0, 3)), 24'($urandom_range(0, 3)),
                           24'($urandom_range(0, 3)));
        end
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got %0h, want %0h at %0t", field, got, want, $time);
        errors++;
    endtask

    always @(posedge clk)
    begin
        bus_step_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_steps.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = expected_steps.pop_front();
                if (bus_request !== e.r.req)
                    report_mismatch("bus_request", bus_request, e.r.req);
                if (bus_write !== e.r.wr)
                    report_mismatch("bus_write", bus_write, e.r.wr);
                if (bus_register !== e.r.regsel)
                    report_mismatch("bus_register", bus_register, e.r.regsel);
                if (bus_value !== e.r.value)
                    report_mismatch("bus_value", bus_value, e.r.value);
                if (word_valid !== e.r.wv)
                    report_mismatch("word_valid", word_valid, e.r.wv);
                if (sector_word !== e.r.word)
                    report_mismatch("sector_word", sector_word, e.r.word);
                if (finished !== e.r.fin)
                    report_mismatch("finished", finished, e.r.fin);
                if (outcome !== e.r.oc)
                    report_mismatch("outcome", outcome, e.r.oc);
                if (last !== e.last)
                    report_mismatch("last", last, e.last);
            end
        end
    end

    initial
    begin
        int p;
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                n = 0;
                while (n < 300)
                begin
                    @(posedge clk);
                    n++;
                end
                hold_request = 1'b0;
            end
            p = $urandom_range(0, 99);
            if (p < 8)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else if (p < 60)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (p < 92 ? $urandom_range(1, 3) : $urandom_range(5, 30))
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = '0;
        lba = '0;
        drive_slave = 1'b0;
        status_byte = '0;
        data_word = '0;
        errors = 0;
        items_sent = 0;
        hold_request = 1'b0;
        quiet_sender = 1'b0;
        busy_limit = RST_BUSY_LIMIT;
        drq_limit = RST_DRQ_LIMIT;
        ident_limit = RST_IDENT_LIMIT;
        seq_phase = PH_IDLE;
        seq_op = OP_READ;
        seq_addr = '0;
        poll_cnt = '0;
        word_cnt = '0;
        first_poll = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_sectors();
        test_limit_extremes();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0 && expected_steps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/aps_pkg.sv
rtl/aps_front.sv
rtl/aps_queue.sv
rtl/aps_back.sv
rtl/ata_pio_sector_sequencer.sv
bench/tb_ata_pio_sector_sequencer.sv
